[hw/rtl/lsfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package lsfc_pkg;

	localparam int IDX_W = 6;
	localparam int CH_W  = 8;
	localparam int CNT_W = 7;

	localparam logic [CNT_W-1:0] LED_COUNT_RST = 7'd64;

	typedef enum logic [1:0] {
		OP_BEGIN = 2'd0,
		OP_STOP  = 2'd1,
		OP_TICK  = 2'd2,
		OP_WRITE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_STOPPED = 2'd0,
		MODE_UP      = 2'd1,
		MODE_RUN     = 2'd2,
		MODE_DOWN    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WALK,
		ST_COPY,
		ST_RESP
	} st_t;

	typedef struct packed {
		op_t              operation;
		logic [IDX_W-1:0] led_index;
		logic [CH_W-1:0]  pixel_red;
		logic [CH_W-1:0]  pixel_green;
		logic [CH_W-1:0]  pixel_blue;
	} in_word_t;

	typedef struct packed {
		logic [IDX_W-1:0] out_index;
		logic [CH_W-1:0]  out_red;
		logic [CH_W-1:0]  out_green;
		logic [CH_W-1:0]  out_blue;
		mode_t            mode_now;
		logic             last;
	} out_word_t;

endpackage

`default_nettype wire

[hw/rtl/led_strip_fade_controller.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel | Handshake             | Word
// --------+-----------------------+-----------------------------------------
// in      | in_valid / in_stall   | in_word_t: operation, index, RGB
// out     | out_valid / out_stall | out_word_t: index, RGB, mode, last
// cfg     | cfg_valid / cfg_ready | cfg_data: led_count
//
// A tick walks n LEDs, one LED per cycle through the registered pixel memory
// read port while the output is not stalled, after a scan pass when ramping up
// or on a working ramp-down tick, since the new mode must be known before the
// first word leaves. Stop copies n LEDs into the backup store, then answers;
// begin and write answer from the response state once they are taken. Reset
// clears control state and the per-entry valid bits at once, so both stores
// read as black with no clearing pass.
// A stalled output pauses the walk; no new input is taken until done.

module led_strip_fade_controller
	import lsfc_pkg::*;
#(
	parameter int MAX_LEDS = 64
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_word_t         in_word,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_word_t             out_word,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CNT_W-1:0] cfg_data
);

	localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEDS);

	st_t state_q, state_d;
	mode_t mode_q;
	logic phase_q;
	logic [CNT_W-1:0] led_count_q;
	logic mod_up_q, mod_dn_q, diff_q;
	logic [AW-1:0] rd_idx_q;
	logic issued_all_q;

	logic vld_s1, last_s1, pv_s1, bv_s1;
	logic [AW-1:0] idx_s1;
	logic [3*CH_W-1:0] pix_rd_s1, bak_rd_s1;

	logic [3*CH_W-1:0] pix_mem [MAX_LEDS];
	logic [3*CH_W-1:0] bak_mem [MAX_LEDS];
	logic [MAX_LEDS-1:0] pix_vld_q, bak_vld_q;

	out_word_t out_word_q;
	logic out_vld_q;

	logic in_acc, out_free, pass, s1_adv, rd_en, pass_end, load_out;
	logic wr_in_range, pix_we, bak_we;
	logic [AW-1:0] pix_wa;
	logic [3*CH_W-1:0] pix_wd;
	logic [CNT_W-1:0] cnt_c;
	logic [AW-1:0] last_idx;
	logic [2:0][CH_W-1:0] px, bk, nx;
	logic diff_now;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_free  = !out_vld_q || !out_stall;
	assign out_valid = out_vld_q;
	assign out_word  = out_word_q;

	// clamp the walk length to 1..MAX_LEDS
	always_comb begin
		if (led_count_q == '0) begin
			cnt_c = CNT_W'(1);
		end else if (led_count_q > MAX_CNT) begin
			cnt_c = MAX_CNT;
		end else begin
			cnt_c = led_count_q;
		end
		last_idx = AW'(cnt_c - CNT_W'(1));
	end

	assign pass     = (state_q == ST_SCAN) || (state_q == ST_WALK) || (state_q == ST_COPY);
	assign s1_adv   = vld_s1 && ((state_q != ST_WALK) || out_free);
	assign rd_en    = pass && !issued_all_q && (!vld_s1 || s1_adv);
	assign pass_end = s1_adv && last_s1;
	assign load_out = ((state_q == ST_WALK) && s1_adv) || ((state_q == ST_RESP) && out_free);

	// per-channel step of the LED sitting in s1
	always_comb begin
		px = pv_s1 ? pix_rd_s1 : '0;
		bk = bv_s1 ? bak_rd_s1 : '0;
		diff_now = 1'b0;
		for (int c = 0; c < 3; c++) begin
			if (mod_up_q) begin
				diff_now = diff_now | (px[c] != bk[c]);
				if (px[c] < bk[c]) begin
					nx[c] = px[c] + CH_W'(1);
				end else if (px[c] > bk[c]) begin
					nx[c] = px[c] - CH_W'(1);
				end else begin
					nx[c] = px[c];
				end
			end else if (mod_dn_q) begin
				diff_now = diff_now | (px[c] != '0);
				nx[c] = (px[c] != '0) ? px[c] - CH_W'(1) : px[c];
			end else begin
				nx[c] = px[c];
			end
		end
	end

	assign wr_in_range = ({1'b0, in_word.led_index} < MAX_CNT);

	always_comb begin
		if (state_q == ST_IDLE) begin
			pix_we = in_acc && (in_word.operation == OP_WRITE) && wr_in_range;
			pix_wa = AW'(in_word.led_index);
			pix_wd = {in_word.pixel_red, in_word.pixel_green, in_word.pixel_blue};
		end else begin
			pix_we = (state_q == ST_WALK) && s1_adv && (mod_up_q || mod_dn_q);
			pix_wa = idx_s1;
			pix_wd = nx;
		end
	end

	assign bak_we = (state_q == ST_COPY) && s1_adv;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (in_word.operation)
						OP_STOP: state_d = ST_COPY;
						OP_TICK: begin
							if (mode_q == MODE_UP || (mode_q == MODE_DOWN && phase_q)) begin
								state_d = ST_SCAN;
							end else begin
								state_d = ST_WALK;
							end
						end
						default: state_d = ST_RESP;
					endcase
				end
			end
			ST_SCAN: if (pass_end) state_d = ST_WALK;
			ST_WALK: if (pass_end) state_d = ST_IDLE;
			ST_COPY: if (pass_end) state_d = ST_RESP;
			ST_RESP: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_STOPPED;
			phase_q      <= 1'b1;
			led_count_q  <= LED_COUNT_RST;
			mod_up_q     <= 1'b0;
			mod_dn_q     <= 1'b0;
			diff_q       <= 1'b0;
			rd_idx_q     <= '0;
			issued_all_q <= 1'b0;
			vld_s1       <= 1'b0;
			pix_vld_q    <= '0;
			bak_vld_q    <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				led_count_q <= cfg_data;
			end
			if (in_acc) begin
				rd_idx_q     <= '0;
				issued_all_q <= 1'b0;
				diff_q       <= 1'b0;
				mod_up_q     <= 1'b0;
				mod_dn_q     <= 1'b0;
				case (in_word.operation)
					OP_BEGIN: mode_q <= MODE_UP;
					OP_STOP:  mode_q <= MODE_DOWN;
					OP_TICK: begin
						mod_up_q <= (mode_q == MODE_UP);
						mod_dn_q <= (mode_q == MODE_DOWN) && phase_q;
						if (mode_q == MODE_DOWN) begin
							phase_q <= !phase_q;
						end
					end
					default: ;
				endcase
			end else if ((state_q == ST_SCAN) && pass_end) begin
				// rewind for the walk; settle the mode before any word leaves
				rd_idx_q     <= '0;
				issued_all_q <= 1'b0;
				if (!(diff_q || diff_now)) begin
					mode_q <= mod_up_q ? MODE_RUN : MODE_STOPPED;
				end
			end else begin
				if (rd_en) begin
					rd_idx_q <= rd_idx_q + AW'(1);
					if (rd_idx_q == last_idx) begin
						issued_all_q <= 1'b1;
					end
				end
				if ((state_q == ST_SCAN) && s1_adv) begin
					diff_q <= diff_q || diff_now;
				end
			end
			if (rd_en) begin
				vld_s1 <= 1'b1;
			end else if (s1_adv) begin
				vld_s1 <= 1'b0;
			end
			if (pix_we) begin
				pix_vld_q[pix_wa] <= 1'b1;
			end
			if (bak_we) begin
				bak_vld_q[idx_s1] <= 1'b1;
			end
			if (load_out) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// memories and the read stage
	always_ff @(posedge clk) begin
		if (pix_we) begin
			pix_mem[pix_wa] <= pix_wd;
		end
		if (bak_we) begin
			bak_mem[idx_s1] <= px;
		end
		if (rd_en) begin
			pix_rd_s1 <= pix_mem[rd_idx_q];
			bak_rd_s1 <= bak_mem[rd_idx_q];
			pv_s1     <= pix_vld_q[rd_idx_q];
			bv_s1     <= bak_vld_q[rd_idx_q];
			idx_s1    <= rd_idx_q;
			last_s1   <= (rd_idx_q == last_idx);
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (state_q == ST_WALK) begin
				out_word_q.out_index <= IDX_W'(idx_s1);
				out_word_q.out_red   <= nx[2];
				out_word_q.out_green <= nx[1];
				out_word_q.out_blue  <= nx[0];
				out_word_q.last      <= last_s1;
			end else begin
				out_word_q.out_index <= '0;
				out_word_q.out_red   <= '0;
				out_word_q.out_green <= '0;
				out_word_q.out_blue  <= '0;
				out_word_q.last      <= 1'b1;
			end
			out_word_q.mode_now <= mode_q;
		end
	end

`ifndef SYNTHESIS
	a_s1_in_pass: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> (state_q == ST_SCAN || state_q == ST_WALK || state_q == ST_COPY))
		else $error("read stage holds an LED outside a pass");

	a_no_overread: assert property (@(posedge clk) disable iff (!arst_n)
		issued_all_q |-> !rd_en)
		else $error("read issued past the last LED");

	a_accept_empty: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !vld_s1 && !issued_all_q || in_acc && !vld_s1)
		else $error("input taken while a pass is in flight");

	a_mode_steady_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && $past(state_q == ST_WALK)) |-> $stable(mode_q))
		else $error("mode changed during a walk");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
	import lsfc_pkg::*;

	localparam int MAX_LEDS = 64;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	in_word_t         in_word   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_word_t        out_word;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data  = '0;

	// predicted strip state
	bit [7:0]         strip_pix [MAX_LEDS][3];
	bit [7:0]         strip_bak [MAX_LEDS][3];
	mode_t            strip_mode = MODE_STOPPED;
	bit               dim_phase  = 1'b1;
	bit [CNT_W-1:0]   led_cnt    = LED_COUNT_RST;

	out_word_t        expected_words [$];
	int unsigned      mismatches = 0;
	int unsigned      words_sent = 0;
	bit               quiet      = 1'b0;

	led_strip_fade_controller dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic int unsigned walk_len();
		int unsigned n;
		n = 32'(led_cnt);
		if (n == 0)
			n = 1;
		if (n > MAX_LEDS)
			n = MAX_LEDS;
		return n;
	endfunction

	// Apply one accepted word to the predicted strip and queue its results.
	function automatic void advance_strip(in_word_t w);
		int unsigned n;
		bit          done;
		out_word_t   r;
		n = walk_len();
		r = '0;
		case (w.operation)
			OP_TICK: begin
				if (strip_mode == MODE_UP) begin
					done = 1'b1;
					for (int i = 0; i < n; i++)
						for (int c = 0; c < 3; c++)
							if (strip_pix[i][c] != strip_bak[i][c]) begin
								done = 1'b0;
								if (strip_pix[i][c] < strip_bak[i][c])
									strip_pix[i][c]++;
								else
									strip_pix[i][c]--;
							end
					if (done)
						strip_mode = MODE_RUN;
				end else if (strip_mode == MODE_DOWN) begin
					if (!dim_phase) begin
						dim_phase = 1'b1;
					end else begin
						dim_phase = 1'b0;
						done = 1'b1;
						for (int i = 0; i < n; i++)
							for (int c = 0; c < 3; c++)
								if (strip_pix[i][c] != 0) begin
									done = 1'b0;
									strip_pix[i][c]--;
								end
						if (done)
							strip_mode = MODE_STOPPED;
					end
				end
				for (int i = 0; i < n; i++) begin
					r.out_index = i[IDX_W-1:0];
					r.out_red   = strip_pix[i][0];
					r.out_green = strip_pix[i][1];
					r.out_blue  = strip_pix[i][2];
					r.mode_now  = strip_mode;
					r.last      = (i == n - 1);
					expected_words.push_back(r);
				end
			end
			OP_BEGIN: begin
				strip_mode = MODE_UP;
			end
			OP_STOP: begin
				for (int i = 0; i < n; i++)
					strip_bak[i] = strip_pix[i];
				strip_mode = MODE_DOWN;
			end
			default: begin
				strip_pix[w.led_index][0] = w.pixel_red;
				strip_pix[w.led_index][1] = w.pixel_green;
				strip_pix[w.led_index][2] = w.pixel_blue;
			end
		endcase
		if (w.operation != OP_TICK) begin
			r.mode_now = strip_mode;
			r.last     = 1'b1;
			expected_words.push_back(r);
		end
	endfunction

	function automatic in_word_t make_word(op_t op);
		in_word_t w;
		w.operation   = op;
		w.led_index   = IDX_W'($urandom_range(MAX_LEDS - 1));
		w.pixel_red   = CH_W'($urandom_range(255));
		w.pixel_green = CH_W'($urandom_range(255));
		w.pixel_blue  = CH_W'($urandom_range(255));
		return w;
	endfunction

	function automatic in_word_t pixel_word(int idx, int red, int green, int blue);
		in_word_t w;
		w.operation   = OP_WRITE;
		w.led_index   = IDX_W'(idx);
		w.pixel_red   = CH_W'(red);
		w.pixel_green = CH_W'(green);
		w.pixel_blue  = CH_W'(blue);
		return w;
	endfunction

	task automatic flag_mismatch(string what, out_word_t want, out_word_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s: expected idx %0d rgb %0d %0d %0d mode %0d last %0d",
				$realtime, what, want.out_index, want.out_red, want.out_green,
				want.out_blue, want.mode_now, want.last);
			$display("%0t: %s: got      idx %0d rgb %0d %0d %0d mode %0d last %0d",
				$realtime, what, got.out_index, got.out_red, got.out_green,
				got.out_blue, got.mode_now, got.last);
		end
	endtask

	always @(posedge clk) begin : check_out
		out_word_t want;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_words.size() == 0) begin
				flag_mismatch("unexpected word", '0, out_word);
			end else begin
				want = expected_words.pop_front();
				if (out_word !== want)
					flag_mismatch("wrong word", want, out_word);
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= !quiet && ($urandom_range(99) < 14);
	end

	task automatic send_word(in_word_t w);
		if (!quiet && $urandom_range(99) < 14) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall !== 1'b0);
		advance_strip(w);
		words_sent++;
	endtask

	// Hold input until every queued word is out, then let the block settle.
	task automatic wait_drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_led_count(int unsigned v);
		wait_drain();
		cfg_valid <= 1'b1;
		cfg_data  <= CNT_W'(v);
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		led_cnt = CNT_W'(v);
	endtask

	task automatic test_fade_basics();
		send_word(make_word(OP_TICK));
		send_word(pixel_word(0, 8'hff, 8'h00, 8'haa));
		send_word(pixel_word(63, 8'h00, 8'hff, 8'h55));
		send_word(pixel_word(1, 1, 2, 3));
		send_word(make_word(OP_TICK));
		send_word(make_word(OP_STOP));
		repeat (3) send_word(make_word(OP_TICK));
		// begin mid fade, then push one LED above its target
		send_word(make_word(OP_BEGIN));
		send_word(pixel_word(1, 9, 9, 9));
		repeat (2) send_word(make_word(OP_TICK));
		send_word(make_word(OP_STOP));
	endtask

	task automatic test_count_limits();
		int k;
		set_led_count(1);
		send_word(pixel_word(0, 1, 0, 0));
		send_word(make_word(OP_STOP));
		for (k = 0; k < 6 && strip_mode == MODE_DOWN; k++)
			send_word(make_word(OP_TICK));
		send_word(make_word(OP_BEGIN));
		for (k = 0; k < 4 && strip_mode == MODE_UP; k++)
			send_word(make_word(OP_TICK));
		send_word(make_word(OP_BEGIN));
		send_word(make_word(OP_TICK));
		set_led_count(0);
		send_word(make_word(OP_TICK));
		send_word(pixel_word(40, 7, 7, 7));
		set_led_count(127);
		send_word(make_word(OP_TICK));
		set_led_count(100);
		send_word(make_word(OP_TICK));
	endtask

	function automatic int unsigned pick_count();
		case ($urandom_range(9))
			0: return MAX_LEDS;
			1: return 1;
			2: return $urandom_range(127);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	function automatic in_word_t random_pixel();
		in_word_t w;
		w = make_word(OP_WRITE);
		if ($urandom_range(3) != 0)
			w.led_index = IDX_W'($urandom_range(walk_len() - 1));
		// keep most values low so fades run to completion
		if ($urandom_range(7) != 0) begin
			w.pixel_red   = CH_W'($urandom_range(7));
			w.pixel_green = CH_W'($urandom_range(7));
			w.pixel_blue  = CH_W'($urandom_range(7));
		end
		return w;
	endfunction

	task automatic test_random_fades(int unsigned target);
		int unsigned start;
		int unsigned done_cnt;
		int          k;
		int          cut;
		start = words_sent;
		done_cnt = 0;
		while (done_cnt < target) begin
			quiet = (done_cnt >= target / 3) && (done_cnt < target / 2);
			if ($urandom_range(3) == 0)
				set_led_count(pick_count());
			repeat ($urandom_range(1, 4)) send_word(random_pixel());
			if ($urandom_range(4) == 0)
				repeat ($urandom_range(1, 3)) send_word(make_word(op_t'($urandom_range(3))));
			send_word(make_word(OP_STOP));
			cut = ($urandom_range(9) == 0) ? $urandom_range(1, 5) : 24;
			for (k = 0; k < cut && strip_mode == MODE_DOWN; k++) begin
				if ($urandom_range(15) == 0)
					send_word(random_pixel());
				send_word(make_word(OP_TICK));
			end
			send_word(make_word(OP_BEGIN));
			cut = ($urandom_range(9) == 0) ? $urandom_range(1, 5) : 24;
			for (k = 0; k < cut && strip_mode == MODE_UP; k++)
				send_word(make_word(OP_TICK));
			repeat ($urandom_range(0, 2)) send_word(make_word(OP_TICK));
			if ($urandom_range(7) == 0)
				wait_drain();
			done_cnt = words_sent - start;
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_fade_basics();
		test_count_limits();
		set_led_count(MAX_LEDS);
		test_random_fades(440);
		wait_drain();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

[files.f]
hw/rtl/lsfc_pkg.sv
hw/rtl/led_strip_fade_controller.sv
tb/testbench.sv
